/* hdl/waypoint_path_follower_unit_macros.svh */
// assertion macros for the waypoint path follower
`ifndef WAYPOINT_PATH_FOLLOWER_UNIT_MACROS_SVH
`define WAYPOINT_PATH_FOLLOWER_UNIT_MACROS_SVH

// same-cycle implication
`define WPF_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("waypoint path follower check failed");

// next-cycle implication
`define WPF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("waypoint path follower check failed");

`endif

/* hdl/wpf_pkg.sv */
// shared constants and types of the waypoint path follower
`default_nettype none
package wpf_pkg;

   localparam int MAX_POINTS = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int COORD_W    = 24;
   localparam int SPEED_W    = 20;
   localparam int DT_W       = 16;
   localparam int ACT_W      = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 20;
   localparam int WP_W       = 2 * COORD_W;

   localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_START = 2'd1;
   localparam logic [ACT_W-1:0] ACT_TICK  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_POINTS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED  = 1'd1;

   localparam logic [31:0] GUESS_LO     = 32'd912680550;
   localparam logic [31:0] GUESS_HI     = 32'd644245094;
   localparam logic [35:0] THREE_Q30    = 36'h0_C000_0000;
   localparam logic [2:0]  NEWTON_LAST  = 3'd4;

   typedef enum logic [4:0] {
      OP_NOP, OP_LOAD, OP_STRD, OP_STSET, OP_SETDN, OP_RDP, OP_RDC, OP_DIF,
      OP_SQX, OP_SQY, OP_SUM, OP_NSHIFT, OP_GUESS, OP_VZERO, OP_NWSQ, OP_NWMY,
      OP_NWT, OP_NWMT, OP_NWY, OP_UX, OP_UY, OP_VX, OP_VY, OP_VW, OP_STX,
      OP_STY, OP_DTX, OP_DTY, OP_DTS, OP_UPD
   } op_type;

   typedef struct packed {
      op_type op;
      logic   capture;
      logic   rsp_load;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic tgt_bad;
      logic m_zero;
      logic m_low;
      logic m_high;
   } status_type;

endpackage
`default_nettype wire

/* hdl/wpf_ram.sv */
// generic single-port-write ram with registered read
`default_nettype none
module wpf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

/* hdl/wpf_ctrl.sv */
// sequencing state machine of the waypoint path follower
`default_nettype none
module wpf_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [wpf_pkg::ACT_W-1:0] req_action,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   input  wire wpf_pkg::status_type       status,
   output wpf_pkg::cmd_type               cmd
);
   import wpf_pkg::*;

   typedef enum logic [28:0] {
      S_IDLE  = 29'h0000001, S_LOAD  = 29'h0000002, S_STRD  = 29'h0000004,
      S_STSET = 29'h0000008, S_SETDN = 29'h0000010, S_RDP   = 29'h0000020,
      S_RDC   = 29'h0000040, S_DIF   = 29'h0000080, S_SQX   = 29'h0000100,
      S_SQY   = 29'h0000200, S_SUM   = 29'h0000400, S_NRM   = 29'h0000800,
      S_NWSQ  = 29'h0001000, S_NWMY  = 29'h0002000, S_NWT   = 29'h0004000,
      S_NWMT  = 29'h0008000, S_NWY   = 29'h0010000, S_UX    = 29'h0020000,
      S_UY    = 29'h0040000, S_VX    = 29'h0080000, S_VY    = 29'h0100000,
      S_VW    = 29'h0200000, S_STX   = 29'h0400000, S_STY   = 29'h0800000,
      S_DTX   = 29'h1000000, S_DTY   = 29'h2000000, S_DTS   = 29'h4000000,
      S_UPD   = 29'h8000000, S_OUT   = 29'h10000000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] iter_ff, iter_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      cmd.op       = OP_NOP;
      cmd.capture  = 1'b0;
      cmd.rsp_load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_action)
                  ACT_LOAD:  state_in = S_LOAD;
                  ACT_START: state_in = S_STRD;
                  ACT_TICK: begin
                     if (status.done) begin
                        state_in = S_OUT;
                     end else if (status.tgt_bad) begin
                        state_in = S_SETDN;
                     end else begin
                        state_in = S_RDP;
                     end
                  end
                  default:   state_in = S_OUT;
               endcase
            end
         end
         S_LOAD:  begin cmd.op = OP_LOAD;  state_in = S_OUT;   end
         S_STRD:  begin cmd.op = OP_STRD;  state_in = S_STSET; end
         S_STSET: begin cmd.op = OP_STSET; state_in = S_OUT;   end
         S_SETDN: begin cmd.op = OP_SETDN; state_in = S_OUT;   end
         S_RDP:   begin cmd.op = OP_RDP;   state_in = S_RDC;   end
         S_RDC:   begin cmd.op = OP_RDC;   state_in = S_DIF;   end
         S_DIF:   begin cmd.op = OP_DIF;   state_in = S_SQX;   end
         S_SQX:   begin cmd.op = OP_SQX;   state_in = S_SQY;   end
         S_SQY:   begin cmd.op = OP_SQY;   state_in = S_SUM;   end
         S_SUM:   begin cmd.op = OP_SUM;   state_in = S_NRM;   end
         S_NRM: begin
            if (status.m_zero) begin
               cmd.op   = OP_VZERO;
               state_in = S_STX;
            end else if (!status.m_low && !status.m_high) begin
               cmd.op   = OP_GUESS;
               iter_in  = '0;
               state_in = S_NWSQ;
            end else begin
               cmd.op = OP_NSHIFT;
            end
         end
         S_NWSQ:  begin cmd.op = OP_NWSQ;  state_in = S_NWMY;  end
         S_NWMY:  begin cmd.op = OP_NWMY;  state_in = S_NWT;   end
         S_NWT:   begin cmd.op = OP_NWT;   state_in = S_NWMT;  end
         S_NWMT:  begin cmd.op = OP_NWMT;  state_in = S_NWY;   end
         S_NWY: begin
            cmd.op   = OP_NWY;
            iter_in  = iter_ff + 3'd1;
            state_in = (iter_ff == NEWTON_LAST) ? S_UX : S_NWSQ;
         end
         S_UX:    begin cmd.op = OP_UX;    state_in = S_UY;    end
         S_UY:    begin cmd.op = OP_UY;    state_in = S_VX;    end
         S_VX:    begin cmd.op = OP_VX;    state_in = S_VY;    end
         S_VY:    begin cmd.op = OP_VY;    state_in = S_VW;    end
         S_VW:    begin cmd.op = OP_VW;    state_in = S_STX;   end
         S_STX:   begin cmd.op = OP_STX;   state_in = S_STY;   end
         S_STY:   begin cmd.op = OP_STY;   state_in = S_DTX;   end
         S_DTX:   begin cmd.op = OP_DTX;   state_in = S_DTY;   end
         S_DTY:   begin cmd.op = OP_DTY;   state_in = S_DTS;   end
         S_DTS:   begin cmd.op = OP_DTS;   state_in = S_UPD;   end
         S_UPD:   begin cmd.op = OP_UPD;   state_in = S_OUT;   end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

/* hdl/wpf_datapath.sv */
// registers, shared multiplier and waypoint store of the path follower
`default_nettype none
module wpf_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire wpf_pkg::cmd_type                    cmd,
   output wpf_pkg::status_type                      status,
   input  wire logic        [wpf_pkg::IDX_W-1:0]    req_point_index,
   input  wire logic signed [wpf_pkg::COORD_W-1:0]  req_point_x,
   input  wire logic signed [wpf_pkg::COORD_W-1:0]  req_point_y,
   input  wire logic        [wpf_pkg::DT_W-1:0]     req_time_step,
   input  wire logic                                csr_write,
   input  wire logic        [wpf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic        [wpf_pkg::CSR_DATA_W-1:0] csr_data,
   output logic signed      [wpf_pkg::COORD_W-1:0]  rsp_vel_x,
   output logic signed      [wpf_pkg::COORD_W-1:0]  rsp_vel_y,
   output logic signed      [wpf_pkg::COORD_W-1:0]  rsp_pos_x,
   output logic signed      [wpf_pkg::COORD_W-1:0]  rsp_pos_y,
   output logic             [wpf_pkg::CNT_W-1:0]    rsp_target_index,
   output logic                                     rsp_finished
);
   import wpf_pkg::*;

   // architectural state
   logic        [CNT_W-1:0]   points_ff, points_in;
   logic        [SPEED_W-1:0] speed_ff, speed_in;
   logic signed [COORD_W-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [COORD_W-1:0] vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;
   logic        [CNT_W-1:0]   tgt_ff, tgt_in;
   logic                      done_ff, done_in;

   // beat and working registers
   logic        [IDX_W-1:0]   idx_ff, idx_in;
   logic signed [COORD_W-1:0] ptx_ff, ptx_in, pty_ff, pty_in;
   logic        [DT_W-1:0]    dt_ff, dt_in;
   logic signed [COORD_W-1:0] prv_x_ff, prv_x_in, prv_y_ff, prv_y_in;
   logic                      dxneg_ff, dxneg_in, dyneg_ff, dyneg_in;
   logic        [COORD_W:0]   ax_ff, ax_in, ay_ff, ay_in;
   logic signed [COORD_W:0]   ndx_ff, ndx_in, ndy_ff, ndy_in;
   logic        [49:0]        len2_ff, len2_in, m_ff, m_in;
   logic signed [4:0]         j_ff, j_in;
   logic        [31:0]        y_ff, y_in, tn_ff, tn_in, ux_ff, ux_in, uy_ff, uy_in;
   logic signed [COORD_W-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic signed [50:0]        dot_ff, dot_in;
   logic signed [65:0]        prod_ff;
   logic signed [32:0]        mul_a, mul_b;

   // response register
   logic signed [COORD_W-1:0] r_vx_ff, r_vy_ff, r_px_ff, r_py_ff;
   logic        [CNT_W-1:0]   r_tgt_ff;
   logic                      r_done_ff;

   logic        [CNT_W-1:0]   n_cnt;
   logic        [IDX_W-1:0]   rd_addr;
   logic        [WP_W-1:0]    rd_data;
   logic signed [COORD_W-1:0] rd_x, rd_y;
   logic                      ram_we;
   logic signed [COORD_W:0]   dxv, dyv;
   logic        [COORD_W-1:0] abs_vx, abs_vy;
   logic        [4:0]         sh;
   logic        [65:0]        shifted;
   logic        [35:0]        pval;
   logic        [31:0]        tval;
   logic        [COORD_W-1:0] vmag, smag;
   logic        [CNT_W-1:0]   tgt_nx;

   wpf_ram #(.WIDTH(WP_W), .DEPTH(MAX_POINTS)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data ({ptx_ff, pty_ff}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign n_cnt  = (points_ff > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : points_ff;
   assign rd_x   = $signed(rd_data[WP_W-1:COORD_W]);
   assign rd_y   = $signed(rd_data[COORD_W-1:0]);
   assign ram_we = (cmd.op == OP_LOAD);
   assign dxv    = {rd_x[COORD_W-1], rd_x} - {prv_x_ff[COORD_W-1], prv_x_ff};
   assign dyv    = {rd_y[COORD_W-1], rd_y} - {prv_y_ff[COORD_W-1], prv_y_ff};
   assign abs_vx = vel_x_ff[COORD_W-1] ? COORD_W'(-vel_x_ff) : COORD_W'(vel_x_ff);
   assign abs_vy = vel_y_ff[COORD_W-1] ? COORD_W'(-vel_y_ff) : COORD_W'(vel_y_ff);
   assign sh      = 5'd15 - 5'(j_ff);
   assign shifted = $unsigned(prod_ff) >> sh;
   assign pval    = prod_ff[65:30];
   assign tval    = (pval > THREE_Q30) ? 32'd0 : 32'(THREE_Q30 - pval);
   assign vmag    = prod_ff[53:30];
   assign smag    = prod_ff[39:16];
   assign tgt_nx  = tgt_ff + CNT_W'(1);

   assign status.done    = done_ff;
   assign status.tgt_bad = (tgt_ff == '0) || (tgt_ff >= n_cnt);
   assign status.m_zero  = (m_ff == '0);
   assign status.m_low   = (m_ff[49:30] == '0);
   assign status.m_high  = (m_ff[49:32] != '0);

   always_comb begin
      case (cmd.op)
         OP_RDP:  rd_addr = IDX_W'(tgt_ff - CNT_W'(1));
         OP_RDC:  rd_addr = IDX_W'(tgt_ff);
         default: rd_addr = '0;
      endcase
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_SQX:  begin mul_a = $signed(33'(ax_ff)); mul_b = $signed(33'(ax_ff)); end
         OP_SQY:  begin mul_a = $signed(33'(ay_ff)); mul_b = $signed(33'(ay_ff)); end
         OP_NWSQ: begin mul_a = $signed(33'(y_ff));  mul_b = $signed(33'(y_ff));  end
         OP_NWMY: begin
            mul_a = $signed(33'(m_ff[31:0]));
            mul_b = $signed(33'(prod_ff[61:30]));
         end
         OP_NWMT: begin mul_a = $signed(33'(y_ff));  mul_b = $signed(33'(tn_ff)); end
         OP_UX:   begin mul_a = $signed(33'(ax_ff)); mul_b = $signed(33'(y_ff));  end
         OP_UY:   begin mul_a = $signed(33'(ay_ff)); mul_b = $signed(33'(y_ff));  end
         OP_VX:   begin mul_a = $signed(33'(ux_ff)); mul_b = $signed(33'(speed_ff)); end
         OP_VY:   begin mul_a = $signed(33'(uy_ff)); mul_b = $signed(33'(speed_ff)); end
         OP_STX:  begin mul_a = $signed(33'(abs_vx)); mul_b = $signed(33'(dt_ff)); end
         OP_STY:  begin mul_a = $signed(33'(abs_vy)); mul_b = $signed(33'(dt_ff)); end
         OP_DTX:  begin mul_a = 33'(ndx_ff); mul_b = 33'(vel_x_ff); end
         OP_DTY:  begin mul_a = 33'(ndy_ff); mul_b = 33'(vel_y_ff); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_comb begin
      points_in = points_ff; speed_in = speed_ff;
      pos_x_in = pos_x_ff; pos_y_in = pos_y_ff;
      vel_x_in = vel_x_ff; vel_y_in = vel_y_ff;
      tgt_in = tgt_ff; done_in = done_ff;
      idx_in = idx_ff; ptx_in = ptx_ff; pty_in = pty_ff; dt_in = dt_ff;
      prv_x_in = prv_x_ff; prv_y_in = prv_y_ff;
      dxneg_in = dxneg_ff; dyneg_in = dyneg_ff;
      ax_in = ax_ff; ay_in = ay_ff; ndx_in = ndx_ff; ndy_in = ndy_ff;
      len2_in = len2_ff; m_in = m_ff; j_in = j_ff;
      y_in = y_ff; tn_in = tn_ff; ux_in = ux_ff; uy_in = uy_ff;
      sx_in = sx_ff; sy_in = sy_ff; dot_in = dot_ff;

      if (csr_write) begin
         case (csr_index)
            REG_POINTS: points_in = CNT_W'(csr_data);
            REG_SPEED:  speed_in  = SPEED_W'(csr_data);
            default:    points_in = points_ff;
         endcase
      end

      if (cmd.capture) begin
         idx_in = req_point_index;
         ptx_in = req_point_x;
         pty_in = req_point_y;
         dt_in  = req_time_step;
      end

      case (cmd.op)
         OP_STSET: begin
            pos_x_in = rd_x;
            pos_y_in = rd_y;
            vel_x_in = '0;
            vel_y_in = '0;
            tgt_in   = CNT_W'(1);
            done_in  = (n_cnt < CNT_W'(2));
         end
         OP_SETDN: done_in = 1'b1;
         OP_RDC: begin
            prv_x_in = rd_x;
            prv_y_in = rd_y;
         end
         OP_DIF: begin
            dxneg_in = dxv[COORD_W];
            dyneg_in = dyv[COORD_W];
            ax_in    = dxv[COORD_W] ? $unsigned(-dxv) : $unsigned(dxv);
            ay_in    = dyv[COORD_W] ? $unsigned(-dyv) : $unsigned(dyv);
            ndx_in   = {rd_x[COORD_W-1], rd_x} - {pos_x_ff[COORD_W-1], pos_x_ff};
            ndy_in   = {rd_y[COORD_W-1], rd_y} - {pos_y_ff[COORD_W-1], pos_y_ff};
         end
         OP_SQY: len2_in = prod_ff[49:0];
         OP_SUM: begin
            m_in = len2_ff + prod_ff[49:0];
            j_in = '0;
         end
         OP_NSHIFT: begin
            if (status.m_low) begin
               m_in = m_ff << 2;
               j_in = j_ff + 5'sd1;
            end else begin
               m_in = m_ff >> 2;
               j_in = j_ff - 5'sd1;
            end
         end
         OP_GUESS: y_in = m_ff[31] ? GUESS_HI : GUESS_LO;
         OP_VZERO: begin
            vel_x_in = '0;
            vel_y_in = '0;
         end
         OP_NWT: tn_in = tval;
         OP_NWY: y_in  = prod_ff[62:31];
         OP_UY:  ux_in = shifted[31:0];
         OP_VX:  uy_in = shifted[31:0];
         OP_VY:  vel_x_in = dxneg_ff ? -$signed(vmag) : $signed(vmag);
         OP_VW:  vel_y_in = dyneg_ff ? -$signed(vmag) : $signed(vmag);
         OP_STY: sx_in = vel_x_ff[COORD_W-1] ? -$signed(smag) : $signed(smag);
         OP_DTX: sy_in = vel_y_ff[COORD_W-1] ? -$signed(smag) : $signed(smag);
         OP_DTY: dot_in = prod_ff[50:0];
         OP_DTS: dot_in = dot_ff + prod_ff[50:0];
         OP_UPD: begin
            if ((dt_ff != '0) && dot_ff[50]) begin
               tgt_in = tgt_nx;
               if (tgt_nx >= n_cnt) begin
                  done_in = 1'b1;
               end
            end
            pos_x_in = pos_x_ff + sx_ff;
            pos_y_in = pos_y_ff + sy_ff;
         end
         default: dot_in = dot_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= '0;
         speed_ff  <= '0;
         pos_x_ff  <= '0;
         pos_y_ff  <= '0;
         vel_x_ff  <= '0;
         vel_y_ff  <= '0;
         tgt_ff    <= CNT_W'(1);
         done_ff   <= 1'b1;
      end else begin
         points_ff <= points_in;
         speed_ff  <= speed_in;
         pos_x_ff  <= pos_x_in;
         pos_y_ff  <= pos_y_in;
         vel_x_ff  <= vel_x_in;
         vel_y_ff  <= vel_y_in;
         tgt_ff    <= tgt_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      ptx_ff   <= ptx_in;
      pty_ff   <= pty_in;
      dt_ff    <= dt_in;
      prv_x_ff <= prv_x_in;
      prv_y_ff <= prv_y_in;
      dxneg_ff <= dxneg_in;
      dyneg_ff <= dyneg_in;
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      ndx_ff   <= ndx_in;
      ndy_ff   <= ndy_in;
      len2_ff  <= len2_in;
      m_ff     <= m_in;
      j_ff     <= j_in;
      y_ff     <= y_in;
      tn_ff    <= tn_in;
      ux_ff    <= ux_in;
      uy_ff    <= uy_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      dot_ff   <= dot_in;
      prod_ff  <= mul_a * mul_b;
      if (cmd.rsp_load) begin
         r_vx_ff   <= vel_x_ff;
         r_vy_ff   <= vel_y_ff;
         r_px_ff   <= pos_x_ff;
         r_py_ff   <= pos_y_ff;
         r_tgt_ff  <= tgt_ff;
         r_done_ff <= done_ff;
      end
   end

   assign rsp_vel_x        = r_vx_ff;
   assign rsp_vel_y        = r_vy_ff;
   assign rsp_pos_x        = r_px_ff;
   assign rsp_pos_y        = r_py_ff;
   assign rsp_target_index = r_tgt_ff;
   assign rsp_finished     = r_done_ff;

endmodule
`default_nettype wire

/* hdl/waypoint_path_follower_unit.sv */
// top level of the constant-speed waypoint path follower
// The req channel takes one beat per command: load a waypoint into a slot,
// start the path at waypoint 0, or advance time by req_time_step. Every beat
// gives exactly one rsp beat with velocity, position, target and finished
// as they stand after that command. The csr port sets the number of points
// in use and the speed; write it only while the unit is idle.
// One command is in work at a time; req_stall is high while it runs.
// A tick runs through the single shared 33x33 multiplier, the
// 2-bit-per-cycle normalize of the squared length and five Newton
// reciprocal square root steps; a zero-length segment skips the
// normalize and the Newton steps. A finished tick answers without
// computing, and an out-of-range tick first marks the path finished.
// A finished rsp beat sits in an output register, so the next command is
// accepted while rsp_stall holds it; that command then waits at its end.
// Reset (synchronous, active high) clears position and velocity, sets the
// target to 1 and marks the path finished; waypoint slots are undefined
// until loaded.
`default_nettype none
`include "waypoint_path_follower_unit_macros.svh"
module waypoint_path_follower_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic        [wpf_pkg::ACT_W-1:0]      req_action,
   input  wire logic        [wpf_pkg::IDX_W-1:0]      req_point_index,
   input  wire logic signed [wpf_pkg::COORD_W-1:0]    req_point_x,
   input  wire logic signed [wpf_pkg::COORD_W-1:0]    req_point_y,
   input  wire logic        [wpf_pkg::DT_W-1:0]       req_time_step,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed      [wpf_pkg::COORD_W-1:0]    rsp_vel_x,
   output logic signed      [wpf_pkg::COORD_W-1:0]    rsp_vel_y,
   output logic signed      [wpf_pkg::COORD_W-1:0]    rsp_pos_x,
   output logic signed      [wpf_pkg::COORD_W-1:0]    rsp_pos_y,
   output logic             [wpf_pkg::CNT_W-1:0]      rsp_target_index,
   output logic                                       rsp_finished,
   input  wire logic                                  csr_write,
   input  wire logic        [wpf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic        [wpf_pkg::CSR_DATA_W-1:0] csr_data
);
   import wpf_pkg::*;

   cmd_type    cmd;
   status_type status;

   wpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd)
   );

   wpf_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_point_index  (req_point_index),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_time_step    (req_time_step),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_vel_x        (rsp_vel_x),
      .rsp_vel_y        (rsp_vel_y),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_target_index (rsp_target_index),
      .rsp_finished     (rsp_finished)
   );

   `WPF_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   `WPF_ASSERT_IMPL(a_target_nonzero, rsp_valid, rsp_target_index != '0)

endmodule
`default_nettype wire
